// ----- hw/rtl/srs_pkg.sv -----
`timescale 1ns / 1ps

package srs_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int OUT_WIDTH   = 16;
   localparam int SYM_WIDTH   = 8;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [OUT_WIDTH-1:0]   out_type;
   typedef logic [SYM_WIDTH-1:0]   sym_type;

   typedef struct packed {
      sym_type symbol;
      logic    end_of_text;
   } srs_item_type;

   typedef struct packed {
      out_type match_total;
      out_type run_bytes_total;
      out_type longest_run;
      out_type longest_run_ties;
      out_type run_total;
   } srs_result_type;

   function automatic count_type sat_add(count_type a, count_type b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   function automatic out_type sat_out(count_type v);
      if ((COUNT_WIDTH > OUT_WIDTH) && ((v >> OUT_WIDTH) != '0)) begin
         return '1;
      end
      return out_type'(v);
   endfunction

endpackage

// ----- hw/rtl/srs_req_if.sv -----
`timescale 1ns / 1ps

interface srs_req_if;
   import srs_pkg::*;

   logic    valid;
   logic    ready;
   sym_type symbol;
   logic    end_of_text;

   modport source (output valid, output symbol, output end_of_text, input ready);
   modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

// ----- hw/rtl/srs_rsp_if.sv -----
`timescale 1ns / 1ps

interface srs_rsp_if;
   import srs_pkg::*;

   logic    valid;
   logic    ready;
   out_type match_total;
   out_type run_bytes_total;
   out_type longest_run;
   out_type longest_run_ties;
   out_type run_total;

   modport source (
      output valid, output match_total, output run_bytes_total, output longest_run,
      output longest_run_ties, output run_total, input ready
   );
   modport sink (
      input valid, input match_total, input run_bytes_total, input longest_run,
      input longest_run_ties, input run_total, output ready
   );
endinterface

// ----- hw/rtl/srs_stats.sv -----
`timescale 1ns / 1ps

module srs_stats
   import srs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  srs_item_type   item,
   input  sym_type        target,
   output srs_result_type result
);

   localparam logic [1:0] PHASE_NONE = 2'd0;
   localparam logic [1:0] PHASE_ONE  = 2'd1;
   localparam logic [1:0] PHASE_RUN  = 2'd2;
   localparam count_type  RUN_MIN    = count_type'(2);
   localparam count_type  ONE        = count_type'(1);

   logic [1:0] phase_ff, phase_in;
   count_type  cur_ff, cur_in;
   count_type  match_ff, match_in;
   count_type  bytes_ff, bytes_in;
   count_type  longest_ff, longest_in;
   count_type  ties_ff, ties_in;
   count_type  runs_ff, runs_in;

   logic       hit;
   logic       close;
   logic [1:0] phase_a;
   count_type  cur_a;

   always_comb begin
      hit     = (item.symbol == target);
      phase_a = phase_ff;
      cur_a   = cur_ff;
      match_in = match_ff;
      if (hit) begin
         match_in = sat_add(match_ff, ONE);
         case (phase_ff)
            PHASE_NONE: begin
               phase_a = PHASE_ONE;
            end
            PHASE_ONE: begin
               phase_a = PHASE_RUN;
               cur_a   = sat_add(cur_ff, RUN_MIN);
            end
            default: begin
               cur_a = sat_add(cur_ff, ONE);
            end
         endcase
      end

      close      = !hit || item.end_of_text;
      phase_in   = phase_a;
      cur_in     = cur_a;
      bytes_in   = bytes_ff;
      longest_in = longest_ff;
      ties_in    = ties_ff;
      runs_in    = runs_ff;
      if (close) begin
         phase_in = PHASE_NONE;
         cur_in   = '0;
         if (phase_a == PHASE_RUN) begin
            if (cur_a == longest_ff) begin
               ties_in = sat_add(ties_ff, ONE);
            end else if (cur_a > longest_ff) begin
               longest_in = cur_a;
               ties_in    = ONE;
            end
            runs_in  = sat_add(runs_ff, ONE);
            bytes_in = sat_add(bytes_ff, cur_a);
         end
      end

      result.match_total      = sat_out(match_in);
      result.run_bytes_total  = sat_out(bytes_in);
      result.longest_run      = sat_out(longest_in);
      result.longest_run_ties = sat_out(ties_in);
      result.run_total        = sat_out(runs_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_NONE;
         cur_ff     <= '0;
         match_ff   <= '0;
         bytes_ff   <= '0;
         longest_ff <= '0;
         ties_ff    <= '0;
         runs_ff    <= '0;
      end else if (step) begin
         if (item.end_of_text) begin
            phase_ff   <= PHASE_NONE;
            cur_ff     <= '0;
            match_ff   <= '0;
            bytes_ff   <= '0;
            longest_ff <= '0;
            ties_ff    <= '0;
            runs_ff    <= '0;
         end else begin
            phase_ff   <= phase_in;
            cur_ff     <= cur_in;
            match_ff   <= match_in;
            bytes_ff   <= bytes_in;
            longest_ff <= longest_in;
            ties_ff    <= ties_in;
            runs_ff    <= runs_in;
         end
      end
   end

   // open run length is only carried while inside a run
   a_cur_only_in_run: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PHASE_RUN) |-> (cur_ff == '0))
      else $error("open run length outside a run");

   a_longest_ties: assert property (@(posedge clock) disable iff (reset)
      (longest_ff == '0) == (ties_ff == '0))
      else $error("longest length and tie count disagree");

   a_ties_le_runs: assert property (@(posedge clock) disable iff (reset)
      ties_ff <= runs_ff)
      else $error("more ties than runs");

   a_bytes_ge_longest: assert property (@(posedge clock) disable iff (reset)
      bytes_ff >= longest_ff)
      else $error("run bytes below longest run");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (step && item.end_of_text) |=> (match_ff == '0 && runs_ff == '0 && phase_ff == PHASE_NONE))
      else $error("statistics not cleared after last beat");

endmodule

// ----- hw/rtl/symbol_run_statistics_unit.sv -----
`timescale 1ns / 1ps
// channel  | dir | handshake          | payload
// req_bus  | in  | valid/ready        | symbol[7:0], end_of_text
// rsp_bus  | out | valid/ready        | match_total, run_bytes_total, longest_run,
//          |     |                    | longest_run_ties, run_total (16 bit each)
// csr_*    | in  | csr_wr_en, no wait | target_symbol[7:0]
//
// One beat per cycle sustained while not stalled; a result is registered after its last beat
// is taken (input register, then statistics update into the result register).
// The only stall: a last beat waits in the input register while an earlier
// result is still held and not taken; req_bus.ready then drops.
// Synchronous active-high reset clears all counters, the target and both valids.

module symbol_run_statistics_unit
   import srs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   srs_req_if.sink     req_bus,
   srs_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  sym_type     csr_wr_data
);

   sym_type        target_ff, target_in;
   logic           in_valid_ff, in_valid_in;
   srs_item_type   item_ff, item_in;
   logic           rsp_valid_ff, rsp_valid_in;
   srs_result_type rsp_data_ff, rsp_data_in;

   logic           advance;
   logic           accept;
   logic           emit;
   srs_result_type result;

   srs_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .target (target_ff),
      .result (result)
   );

   always_comb begin
      advance = in_valid_ff && (!item_ff.end_of_text || !rsp_valid_ff || rsp_bus.ready);
      req_bus.ready = !in_valid_ff || advance;
      accept  = req_bus.valid && req_bus.ready;
      emit    = advance && item_ff.end_of_text;

      target_in = csr_wr_en ? csr_wr_data : target_ff;

      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      item_in     = item_ff;
      if (accept) begin
         item_in.symbol      = req_bus.symbol;
         item_in.end_of_text = req_bus.end_of_text;
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = emit ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.match_total      = rsp_data_ff.match_total;
   assign rsp_bus.run_bytes_total  = rsp_data_ff.run_bytes_total;
   assign rsp_bus.longest_run      = rsp_data_ff.longest_run;
   assign rsp_bus.longest_run_ties = rsp_data_ff.longest_run_ties;
   assign rsp_bus.run_total        = rsp_data_ff.run_total;

endmodule

// ----- sim/srs_stats_monitor.sv -----
`timescale 1ns / 1ps

module srs_stats_monitor
   import srs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   srs_req_if          req_mon,
   srs_rsp_if          rsp_mon,
   input  logic        csr_wr_en,
   input  sym_type     csr_wr_data,
   output int unsigned mismatch_count,
   output int unsigned stats_awaited
);

   typedef enum logic [1:0] {
      RUN_NONE,
      RUN_SINGLE,
      RUN_OPEN
   } run_state_type;

   localparam longint unsigned OUT_LIMIT   = (64'd1 << OUT_WIDTH) - 64'd1;
   localparam count_type       MIN_RUN_LEN = count_type'(2);
   localparam count_type       ONE         = count_type'(1);

   sym_type        target_byte;
   run_state_type  run_state;
   count_type      open_run_len;
   count_type      match_tally;
   count_type      run_byte_tally;
   count_type      longest_len;
   count_type      longest_ties;
   count_type      run_tally;
   srs_result_type stats_due[$];
   int unsigned    bad_beats = 0;
   int unsigned    due_depth = 0;

   assign mismatch_count = bad_beats;
   assign stats_awaited  = due_depth;

   // a + b overflows exactly when a exceeds the headroom ~b
   function automatic count_type clamp_add(count_type a, count_type b);
      if (a > ~b) begin
         return '1;
      end
      return a + b;
   endfunction

   function automatic out_type clamp_out(count_type v);
      if (64'(v) > OUT_LIMIT) begin
         return '1;
      end
      return out_type'(v);
   endfunction

   function automatic void restart_text();
      run_state      = RUN_NONE;
      open_run_len   = '0;
      match_tally    = '0;
      run_byte_tally = '0;
      longest_len    = '0;
      longest_ties   = '0;
      run_tally      = '0;
   endfunction

   function automatic void close_open_run();
      if (run_state == RUN_OPEN) begin
         if (open_run_len == longest_len) begin
            longest_ties = clamp_add(longest_ties, ONE);
         end else if (open_run_len > longest_len) begin
            longest_len  = open_run_len;
            longest_ties = ONE;
         end
         run_tally      = clamp_add(run_tally, ONE);
         run_byte_tally = clamp_add(run_byte_tally, open_run_len);
         open_run_len   = '0;
      end
      run_state = RUN_NONE;
   endfunction

   function automatic void take_symbol(sym_type sym, logic last);
      srs_result_type stats;
      if (sym == target_byte) begin
         match_tally = clamp_add(match_tally, ONE);
         case (run_state)
            RUN_NONE: begin
               run_state = RUN_SINGLE;
            end
            RUN_SINGLE: begin
               open_run_len = clamp_add(open_run_len, MIN_RUN_LEN);
               run_state    = RUN_OPEN;
            end
            default: begin
               open_run_len = clamp_add(open_run_len, ONE);
            end
         endcase
      end else begin
         close_open_run();
      end
      if (last) begin
         close_open_run();
         stats.match_total      = clamp_out(match_tally);
         stats.run_bytes_total  = clamp_out(run_byte_tally);
         stats.longest_run      = clamp_out(longest_len);
         stats.longest_run_ties = clamp_out(longest_ties);
         stats.run_total        = clamp_out(run_tally);
         stats_due.push_back(stats);
         restart_text();
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] stats mismatch: %s", $time, what);
      bad_beats++;
   endtask

   task automatic check_beat(srs_result_type got);
      srs_result_type due;
      if (stats_due.size() == 0) begin
         report_mismatch("result beat with no text closed");
         return;
      end
      due = stats_due.pop_front();
      if (got.match_total !== due.match_total) begin
         report_mismatch($sformatf("match_total %0d, want %0d",
                                   got.match_total, due.match_total));
      end
      if (got.run_bytes_total !== due.run_bytes_total) begin
         report_mismatch($sformatf("run_bytes_total %0d, want %0d",
                                   got.run_bytes_total, due.run_bytes_total));
      end
      if (got.longest_run !== due.longest_run) begin
         report_mismatch($sformatf("longest_run %0d, want %0d",
                                   got.longest_run, due.longest_run));
      end
      if (got.longest_run_ties !== due.longest_run_ties) begin
         report_mismatch($sformatf("longest_run_ties %0d, want %0d",
                                   got.longest_run_ties, due.longest_run_ties));
      end
      if (got.run_total !== due.run_total) begin
         report_mismatch($sformatf("run_total %0d, want %0d",
                                   got.run_total, due.run_total));
      end
   endtask

   always @(posedge clock) begin
      srs_result_type seen;
      if (reset) begin
         target_byte = '0;
         restart_text();
         stats_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.match_total      = rsp_mon.match_total;
            seen.run_bytes_total  = rsp_mon.run_bytes_total;
            seen.longest_run      = rsp_mon.longest_run;
            seen.longest_run_ties = rsp_mon.longest_run_ties;
            seen.run_total        = rsp_mon.run_total;
            check_beat(seen);
         end
         if (req_mon.valid && req_mon.ready) begin
            take_symbol(req_mon.symbol, req_mon.end_of_text);
         end
         if (csr_wr_en) begin
            target_byte = csr_wr_data;
         end
      end
      due_depth = stats_due.size();
   end

endmodule

// ----- sim/tb_symbol_run_statistics_unit.sv -----
`timescale 1ns / 1ps

module tb_symbol_run_statistics_unit;
   import srs_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   sym_type     csr_wr_data = '0;
   int unsigned mismatch_count;
   int unsigned stats_awaited;
   int unsigned cycle_count   = 0;
   int unsigned req_gap_pct   = 0;
   int unsigned rsp_stall_pct = 0;
   bit          hold_armed    = 1'b0;
   sym_type     target_now    = '0;

   srs_req_if req_bus ();
   srs_rsp_if rsp_bus ();

   symbol_run_statistics_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   srs_stats_monitor stats_mon (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .stats_awaited  (stats_awaited)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold-off when armed
   initial begin
      bit hold_served;
      hold_served   = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_served) begin
            hold_served = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 17)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic offer_beat(sym_type byte_in, logic last_in);
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.symbol      <= byte_in;
      req_bus.end_of_text <= last_in;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_bytes(sym_type seq[$]);
      foreach (seq[i]) begin
         offer_beat(seq[i], i == seq.size() - 1);
      end
   endtask

   task automatic send_text(int unsigned len, int unsigned match_pct);
      sym_type s;
      for (int unsigned i = 0; i < len; i++) begin
         s = ($urandom_range(0, 99) < match_pct) ? target_now
                                                 : sym_type'($urandom_range(0, 255));
         offer_beat(s, i == len - 1);
      end
   endtask

   task automatic random_texts(int unsigned n_items);
      int unsigned sent;
      int unsigned len;
      int unsigned pct;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
         pct = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(50, 95);
         send_text(len, pct);
         sent += len;
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (stats_awaited != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_target(sym_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
      target_now = value;
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.symbol      = '0;
      req_bus.end_of_text = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // target left at its reset value
      send_bytes('{8'h00});
      send_bytes('{8'hFF});
      send_bytes('{8'h00, 8'h00, 8'hFF});
      send_bytes('{8'h00, 8'h00, 8'h00});
      send_bytes('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h02, 8'h00});
      send_bytes('{8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00});
      settle();
      write_target(8'hFF);
      send_bytes('{8'hFF, 8'hFF, 8'h7F});
      settle();

      write_target(sym_type'($urandom_range(1, 254)));
      req_gap_pct   = 15;
      rsp_stall_pct = 10;
      random_texts(500);

      // short texts against a stalled result side, to back up the input
      hold_armed = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_text($urandom_range(1, 4), 70);
      end
      settle();

      write_target(8'h00);
      req_gap_pct   = 25;
      rsp_stall_pct = 25;
      random_texts(450);
      settle();

      write_target(sym_type'($urandom_range(0, 255)));
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      random_texts(400);

      req_bus.valid <= 1'b0;
      while (stats_awaited != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- symbol_run_statistics_unit.f -----
hw/rtl/srs_pkg.sv
hw/rtl/srs_req_if.sv
hw/rtl/srs_rsp_if.sv
hw/rtl/srs_stats.sv
hw/rtl/symbol_run_statistics_unit.sv
sim/srs_stats_monitor.sv
sim/tb_symbol_run_statistics_unit.sv
